### rtl/dtqr_pkg.sv
package dtqr_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [1:0] REG_CAM_X  = 2'd0;
  localparam logic [1:0] REG_CAM_Y  = 2'd1;
  localparam logic [1:0] REG_HALF_H = 2'd2;
  localparam logic [1:0] REG_ASPECT = 2'd3;

  localparam logic [31:0] DEPTH_INF = 32'h7FFF_FFFF;
  localparam logic [7:0]  GLYPH_SPACE = 8'd32;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [7:0]  glyph;
    logic signed [31:0] z;
    logic [7:0]  col0;
    logic [7:0]  col1;
    logic [7:0]  row0;
    logic [7:0]  row1;
    logic        empty;
    logic [7:0]  rd_col;
    logic [7:0]  rd_row;
    logic        rd_ok;
  } job_t;

  function automatic logic [7:0] bg_glyph(input logic [7:0] lum);
    logic [9:0] l3;
    l3 = {2'b00, lum} * 10'd3;
    if (l3 >= 10'd765)      bg_glyph = 8'd45;
    else if (l3 >= 10'd510) bg_glyph = 8'd58;
    else if (l3 >= 10'd255) bg_glyph = 8'd46;
    else                    bg_glyph = 8'd32;
  endfunction

endpackage

### rtl/depth_tested_quad_rasterizer_top.sv
// Z-buffered rectangle rasterizer on a GridCols x GridRows character grid.
// After reset the back clears its grid memories before it carries out
// items; the front may accept and queue up to two items meanwhile. A draw
// maps its quad corners with four serial divides, then reads and then
// tests/writes each covered cell in the depth memory. The front computes
// the next draw's cell span while the back walks the previous one.
module depth_tested_quad_rasterizer_top #(
  parameter int GridCols = 64,
  parameter int GridRows = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // opcode[1:0], luminance[9:2], center_x[41:10], center_y[73:42],
  // center_z[105:74], extent_x[136:106], extent_y[167:137], alpha[175:168],
  // glyph[183:176], read_col[189:184], read_row[194:190]
  input  logic [199:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // cell_glyph[7:0], cells_written[19:8]
  output logic [23:0]  m_axis_tdata_o,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [3:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);
  logic signed [31:0] cam_x_q, cam_y_q;
  logic [30:0] half_h_q, aspect_q;
  logic wr;
  logic [1:0] ridx;
  logic jv, jr, qv_q, bq_ready;
  dtqr_pkg::job_t fj, qj_q;
  logic [7:0] og;
  logic [11:0] ocnt;

  assign pready_o = 1'b1;
  assign wr = psel_i && penable_i && pwrite_i;
  assign ridx = paddr_i[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0; cam_y_q <= '0;
      half_h_q <= 31'd65536; aspect_q <= 31'd65536;
    end else if (wr) begin
      unique case (ridx)
        dtqr_pkg::REG_CAM_X:  cam_x_q <= pwdata_i;
        dtqr_pkg::REG_CAM_Y:  cam_y_q <= pwdata_i;
        dtqr_pkg::REG_HALF_H: half_h_q <= pwdata_i[30:0];
        dtqr_pkg::REG_ASPECT: aspect_q <= pwdata_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      dtqr_pkg::REG_CAM_X:  prdata_o = cam_x_q;
      dtqr_pkg::REG_CAM_Y:  prdata_o = cam_y_q;
      dtqr_pkg::REG_HALF_H: prdata_o = {1'b0, half_h_q};
      dtqr_pkg::REG_ASPECT: prdata_o = {1'b0, aspect_q};
      default:              prdata_o = '0;
    endcase
  end

  dtqr_front #(.GridCols(GridCols), .GridRows(GridRows)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .opcode_i(s_axis_tdata_i[1:0]), .luminance_i(s_axis_tdata_i[9:2]),
    .center_x_i(s_axis_tdata_i[41:10]), .center_y_i(s_axis_tdata_i[73:42]),
    .center_z_i(s_axis_tdata_i[105:74]), .extent_x_i(s_axis_tdata_i[136:106]),
    .extent_y_i(s_axis_tdata_i[167:137]), .alpha_i(s_axis_tdata_i[175:168]),
    .glyph_i(s_axis_tdata_i[183:176]), .read_col_i(s_axis_tdata_i[189:184]),
    .read_row_i(s_axis_tdata_i[194:190]),
    .cam_x_i(cam_x_q), .cam_y_i(cam_y_q), .half_h_i(half_h_q), .aspect_i(aspect_q),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(fj)
  );

  // one-entry queue between front and back
  assign jr = !qv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) qv_q <= 1'b0;
    else if (jv && jr) qv_q <= 1'b1;
    else if (bq_ready) qv_q <= 1'b0;
  end
  always_ff @(posedge clk_i) if (jv && jr) qj_q <= fj;

  dtqr_back #(.GridCols(GridCols), .GridRows(GridRows)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(qv_q), .job_ready_o(bq_ready), .job_i(qj_q),
    .m_valid_o(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i),
    .cell_glyph_o(og), .cells_written_o(ocnt)
  );

  assign m_axis_tdata_o = {4'd0, ocnt, og};
endmodule

### rtl/dtqr_ram.sv
module dtqr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/dtqr_div.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module dtqr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);
  logic [63:0] n_q, n_d;
  logic [32:0] r_q, r_d;
  logic [63:0] q_q, q_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] sh;

  always_comb begin
    n_d = n_q; r_d = r_q; q_d = q_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    sh = {r_q[31:0], n_q[63]};
    if (start_i) begin
      n_d = num_i[63] ? 64'(-num_i) : num_i;
      neg_d = num_i[63];
      den_d = den_i;
      r_d = '0; q_d = '0; cnt_d = 7'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[62:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        r_d = sh - {1'b0, den_q};
        q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = sh;
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; r_q <= r_d; q_q <= q_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

### rtl/dtqr_front.sv
// Front: decodes the item, maps the quad corners to a clamped cell span.
module dtqr_front #(
  parameter int GridCols = 64,
  parameter int GridRows = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          luminance_i,
  input  logic signed [31:0]  center_x_i,
  input  logic signed [31:0]  center_y_i,
  input  logic signed [31:0]  center_z_i,
  input  logic [30:0]         extent_x_i,
  input  logic [30:0]         extent_y_i,
  input  logic [7:0]          alpha_i,
  input  logic [7:0]          glyph_i,
  input  logic [5:0]          read_col_i,
  input  logic [4:0]          read_row_i,
  input  logic signed [31:0]  cam_x_i,
  input  logic signed [31:0]  cam_y_i,
  input  logic [30:0]         half_h_i,
  input  logic [30:0]         aspect_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output dtqr_pkg::job_t      job_o
);
  typedef enum logic [2:0] {
    F_IDLE, F_HW, F_DIV, F_WAIT, F_CELL, F_OUT
  } fst_e;

  fst_e st_q, st_d;
  dtqr_pkg::job_t job_q, job_d;
  logic [1:0] k_q, k_d;
  logic signed [63:0] c_q [4];
  logic signed [63:0] c_d [4];
  logic signed [63:0] n_q [4];
  logic [31:0] hw_q, hh_q;
  logic [61:0] prod_q;
  logic div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic [31:0] div_den;
  logic signed [63:0] hx, hy;
  logic signed [72:0] tx0, tx1, ty0, ty1;
  logic signed [72:0] col_a, col_b, row_a, row_b, lo_c, hi_c, lo_r, hi_r;
  logic [61:0] hw_raw;

  dtqr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign in_ready_o = (st_q == F_IDLE);

  always_comb begin
    hx = 64'(extent_x_i[30:1]);
    hy = 64'(extent_y_i[30:1]);
    c_d[0] = 64'(center_x_i) - hx - 64'(cam_x_i);
    c_d[1] = 64'(center_x_i) + hx - 64'(cam_x_i);
    c_d[2] = 64'(center_y_i) + hy - 64'(cam_y_i);
    c_d[3] = 64'(center_y_i) - hy - 64'(cam_y_i);
    div_num = c_q[k_q] <<< 16;
    div_den = k_q[1] ? hh_q : hw_q;
    hw_raw = prod_q >> 16;
  end

  always_comb begin
    tx0 = (73'(n_q[0]) + 73'sd65536) * $signed(73'(GridCols - 1)) + 73'sd65536;
    tx1 = (73'(n_q[1]) + 73'sd65536) * $signed(73'(GridCols - 1)) + 73'sd65536;
    ty0 = (73'sd65536 - 73'(n_q[2])) * $signed(73'(GridRows - 1)) + 73'sd65536;
    ty1 = (73'sd65536 - 73'(n_q[3])) * $signed(73'(GridRows - 1)) + 73'sd65536;
    col_a = tx0 / 73'sd131072;
    col_b = tx1 / 73'sd131072;
    row_a = ty0 / 73'sd131072;
    row_b = ty1 / 73'sd131072;
    lo_c = (col_a < col_b) ? col_a : col_b;
    hi_c = (col_a < col_b) ? col_b : col_a;
    lo_r = (row_a < row_b) ? row_a : row_b;
    hi_r = (row_a < row_b) ? row_b : row_a;
    if (lo_c < 0) lo_c = '0;
    if (lo_r < 0) lo_r = '0;
    if (hi_c > 73'(GridCols - 1)) hi_c = 73'(GridCols - 1);
    if (hi_r > 73'(GridRows - 1)) hi_r = 73'(GridRows - 1);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      F_IDLE: if (in_valid_i) st_d = (opcode_i == dtqr_pkg::OP_DRAW && alpha_i != 8'd0)
                                   ? F_HW : F_OUT;
      F_HW:   st_d = F_DIV;
      F_DIV:  st_d = F_WAIT;
      F_WAIT: if (div_done) st_d = (k_q == 2'd3) ? F_CELL : F_DIV;
      F_CELL: st_d = F_OUT;
      F_OUT:  if (job_ready_i) st_d = F_IDLE;
      default: st_d = F_IDLE;
    endcase
  end

  always_comb begin
    job_d = job_q;
    k_d = k_q;
    div_start = (st_q == F_DIV);
    if (st_q == F_IDLE && in_valid_i) begin
      job_d.op = dtqr_pkg::op_e'(opcode_i);
      job_d.glyph = (opcode_i == dtqr_pkg::OP_CLEAR) ? dtqr_pkg::bg_glyph(luminance_i)
                                                     : glyph_i;
      job_d.z = center_z_i;
      job_d.empty = 1'b1;
      job_d.col0 = '0; job_d.col1 = '0; job_d.row0 = '0; job_d.row1 = '0;
      job_d.rd_col = 8'(read_col_i);
      job_d.rd_row = 8'(read_row_i);
      job_d.rd_ok = (32'(read_col_i) < 32'(GridCols)) && (32'(read_row_i) < 32'(GridRows));
      k_d = 2'd0;
    end
    if (st_q == F_WAIT && div_done) k_d = k_q + 2'd1;
    if (st_q == F_CELL) begin
      job_d.empty = (lo_c > hi_c) || (lo_r > hi_r);
      job_d.col0 = lo_c[7:0]; job_d.col1 = hi_c[7:0];
      job_d.row0 = lo_r[7:0]; job_d.row1 = hi_r[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
      k_q  <= '0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (st_q == F_IDLE && in_valid_i) begin
      for (int i = 0; i < 4; i++) c_q[i] <= c_d[i];
      prod_q <= 62'(half_h_i) * 62'(aspect_i);
      hh_q <= (half_h_i == '0) ? 32'd1 : 32'(half_h_i);
    end
    if (st_q == F_HW) begin
      if (hw_raw > 62'h7FFF_FFFF) hw_q <= 32'h7FFF_FFFF;
      else if (hw_raw == '0)      hw_q <= 32'd1;
      else                        hw_q <= hw_raw[31:0];
    end
    if (st_q == F_WAIT && div_done) n_q[k_q] <= div_quo;
  end

  assign job_valid_o = (st_q == F_OUT);
  assign job_o = job_q;
endmodule

### rtl/dtqr_back.sv
// Back: walks the grid memories for clear and draw, reads one cell.
module dtqr_back #(
  parameter int GridCols = 64,
  parameter int GridRows = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  dtqr_pkg::job_t  job_i,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic [7:0]      cell_glyph_o,
  output logic [11:0]     cells_written_o
);
  localparam int Cells = GridCols * GridRows;
  localparam int AW = $clog2(Cells);

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_CLR, B_RD, B_TEST, B_RDA, B_RDW, B_OUT
  } bst_e;

  bst_e st_q, st_d;
  dtqr_pkg::job_t job_q;
  logic [7:0] x_q, x_d, y_q, y_d;
  logic [AW:0] clr_q, clr_d;
  logic [11:0] cnt_q, cnt_d;
  logic [7:0] og_q, og_d;
  logic [AW-1:0] addr;
  logic we;
  logic [7:0] wg, rg;
  logic [31:0] wz, rz;

  assign addr = AW'(32'(y_q) * 32'(GridCols) + 32'(x_q));

  dtqr_ram #(.Width(8), .Depth(Cells)) u_glyph (
    .clk_i, .we_i(we), .waddr_i(st_q == B_INIT || st_q == B_CLR ? clr_q[AW-1:0] : addr),
    .wdata_i(wg), .raddr_i(addr), .rdata_o(rg)
  );
  dtqr_ram #(.Width(32), .Depth(Cells)) u_depth (
    .clk_i, .we_i(we), .waddr_i(st_q == B_INIT || st_q == B_CLR ? clr_q[AW-1:0] : addr),
    .wdata_i(wz), .raddr_i(addr), .rdata_o(rz)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_INIT: if (clr_q == (AW+1)'(Cells - 1)) st_d = B_IDLE;
      B_IDLE: if (job_valid_i) begin
        unique case (job_i.op)
          dtqr_pkg::OP_CLEAR: st_d = B_CLR;
          dtqr_pkg::OP_DRAW:  st_d = job_i.empty ? B_OUT : B_RD;
          dtqr_pkg::OP_READ:  st_d = job_i.rd_ok ? B_RDA : B_OUT;
          default:            st_d = B_OUT;
        endcase
      end
      B_CLR:  if (clr_q == (AW+1)'(Cells - 1)) st_d = B_OUT;
      B_RD:   st_d = B_TEST;
      B_TEST: st_d = (x_q == job_q.col1 && y_q == job_q.row1) ? B_OUT : B_RD;
      B_RDA:  st_d = B_RDW;
      B_RDW:  st_d = B_OUT;
      B_OUT:  if (m_ready_i) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_comb begin
    x_d = x_q; y_d = y_q; clr_d = clr_q; cnt_d = cnt_q; og_d = og_q;
    we = 1'b0; wg = job_q.glyph; wz = job_q.z;
    unique case (st_q)
      B_INIT: begin
        we = 1'b1; wg = dtqr_pkg::GLYPH_SPACE; wz = dtqr_pkg::DEPTH_INF;
        clr_d = clr_q + (AW+1)'(1);
      end
      B_IDLE: begin
        clr_d = '0; cnt_d = '0; og_d = '0;
        x_d = job_i.op == dtqr_pkg::OP_READ ? job_i.rd_col : job_i.col0;
        y_d = job_i.op == dtqr_pkg::OP_READ ? job_i.rd_row : job_i.row0;
      end
      B_CLR: begin
        we = 1'b1; wz = dtqr_pkg::DEPTH_INF;
        clr_d = clr_q + (AW+1)'(1);
        cnt_d = cnt_q + 12'd1;
      end
      B_TEST: begin
        if ($signed(job_q.z) <= $signed(rz)) begin
          we = 1'b1;
          cnt_d = cnt_q + 12'd1;
        end
        if (x_q == job_q.col1) begin
          x_d = job_q.col0;
          y_d = y_q + 8'd1;
        end else begin
          x_d = x_q + 8'd1;
        end
        if (x_q == job_q.col1 && y_q == job_q.row1) begin
          x_d = x_q; y_d = y_q;
        end
      end
      B_RDW: og_d = rg;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_INIT; clr_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == B_IDLE) job_q <= job_i;
    x_q <= x_d; y_q <= y_d; cnt_q <= cnt_d; og_q <= og_d;
  end

  assign job_ready_o = (st_q == B_IDLE);
  assign m_valid_o = (st_q == B_OUT);
  assign cell_glyph_o = og_q;
  assign cells_written_o = cnt_q;

  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && !m_ready_i |=> m_valid_o && $stable(cells_written_o))
    else $error("result changed while stalled");
  a_no_write_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o |-> !we) else $error("grid write while presenting result");
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && job_q.op == dtqr_pkg::OP_READ |-> cells_written_o == 12'd0)
    else $error("read reported writes");
endmodule
